// ===== rtl/mkvch_pkg.sv =====
// Shared constants, register codes and types for the two-state Markov channel.
// Used by the serial divider and by the top level; depends on nothing.
package mkvch_pkg;

   // default sizes of the parameterized datapath
   localparam int PROB_FRAC_BITS_DEF = 16;
   localparam int TIME_BITS_DEF      = 32;

   // fixed port widths
   localparam int NOW_W       = 32;
   localparam int DRAW_W      = 16;
   localparam int BER_W       = 33;
   localparam int STEP_W      = 32;
   localparam int CSR_DATA_W  = 33;
   localparam int CSR_INDEX_W = 3;

   // reset value of the step length register
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(5);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BER_GOOD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BER_BAD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROB_GB   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROB_BG   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BAD = 3'd5;

   // status of the shared serial divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/mkvch_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on mkvch_pkg for its status struct.
module mkvch_div #(
   parameter int DW = 34,
   parameter int VW = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DW-1:0]           dividend,
   input  logic [VW-1:0]           divisor,
   output mkvch_pkg::div_stat_type stat,
   output logic [DW-1:0]           quotient,
   output logic [VW-1:0]           remainder
);
   import mkvch_pkg::*;

   localparam int CNT_W = $clog2(DW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    dvs_ff, dvs_in;
   logic [VW:0]      trial;
   logic [VW:0]      diff;
   logic             fits;

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // load on start, then shift one quotient bit in per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/two_state_markov_channel.sv =====
// Two-state (good/bad) Markov channel: sequencer, shared multiplier, registers.
// Depends on mkvch_pkg and instantiates the serial divider mkvch_div.
//
// One request is taken at a time and one response comes back for each. A request
// runs: the elapsed-time divide (DW = max(TIME_BITS, 2*PROB_FRAC_BITS + 2), 34 by
// default), a check state, square-and-multiply on the shared multiplier for each
// bit of the step count, the numerator, the probability divide and an output
// state. A request with no whole step elapsed, or with both transition probabilities
// zero, skips the power and the second divide. Both divides share the single
// serial divider. A finished response waits in its output register while the
// next request is taken. The user must write configuration only while the block
// is idle; the block itself does not enforce it.
module two_state_markov_channel #(
   parameter int PROB_FRAC_BITS = mkvch_pkg::PROB_FRAC_BITS_DEF,
   parameter int TIME_BITS      = mkvch_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mkvch_pkg::NOW_W-1:0]        req_now_ticks,
   input  logic [mkvch_pkg::DRAW_W-1:0]       req_rand_draw,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_channel_bad,
   output logic [mkvch_pkg::BER_W-1:0]        rsp_error_rate,
   input  logic                               csr_wr_en,
   input  logic [mkvch_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mkvch_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mkvch_pkg::*;

   localparam int F   = PROB_FRAC_BITS;
   localparam int TW  = TIME_BITS;
   localparam int PW  = F + 1;                    // probability register width
   localparam int MW  = F + 2;                    // signed Q1.F operand width
   localparam int PRW = 2 * MW;                   // product width
   localparam int DW  = (TW > 2 * F + 2) ? TW : 2 * F + 2;
   localparam int VW  = (STEP_W > MW) ? STEP_W : MW;
   localparam int CW  = DW + DRAW_W;              // draw against probability compare

   localparam logic [PW-1:0]        PROB_ONE = {1'b1, {F{1'b0}}};
   localparam logic signed [MW-1:0] Q_ONE    = {2'b01, {F{1'b0}}};

   // sequencer state codes
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TDIV    = 4'd1;
   localparam logic [3:0] S_CHECK   = 4'd2;
   localparam logic [3:0] S_POW_A   = 4'd3;
   localparam logic [3:0] S_POW_AW  = 4'd4;
   localparam logic [3:0] S_POW_B   = 4'd5;
   localparam logic [3:0] S_POW_BW  = 4'd6;
   localparam logic [3:0] S_NUM_M   = 4'd7;
   localparam logic [3:0] S_NUM_W   = 4'd8;
   localparam logic [3:0] S_PDIV    = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   // configuration registers
   logic [BER_W-1:0]  ber_good_ff;
   logic [BER_W-1:0]  ber_bad_ff;
   logic [PW-1:0]     prob_gb_ff;
   logic [PW-1:0]     prob_bg_ff;
   logic [STEP_W-1:0] step_ff;

   // sequencer and datapath registers
   logic [3:0]               state_ff, state_in;
   logic                     bad_ff, bad_in;
   logic [TW-1:0]            last_ff, last_in;
   logic [TW-1:0]            now_ff;
   logic [DRAW_W-1:0]        draw_ff;
   logic [TW-1:0]            n_ff, n_in;
   logic [TW-1:0]            adv_ff, adv_in;
   logic signed [MW-1:0]     acc_ff, acc_in;
   logic signed [MW-1:0]     base_ff, base_in;
   logic signed [PRW-1:0]    prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_bad_ff, rsp_bad_in;
   logic [BER_W-1:0]         rsp_rate_ff, rsp_rate_in;

   // combinational datapath
   logic [PW-1:0]         pgb, pbg, p_same, p_other;
   logic [MW-1:0]         s_sum;
   logic [STEP_W-1:0]     step_eff;
   logic [TW-1:0]         elapsed;
   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PRW-1:0] mul_p;
   logic [PRW-1:0]        prod_mag, prod_sh, prod_q;
   logic signed [MW-1:0]  trunc_q;
   logic signed [PRW-1:0] num;
   logic [PRW-1:0]        num_mag;
   logic [CW-1:0]         cmp_lhs, cmp_rhs;
   logic                  flip;
   logic                  accept;

   // divider hookup
   logic         div_start;
   logic [DW-1:0] div_dividend;
   logic [VW-1:0] div_divisor;
   div_stat_type  div_stat;
   logic [DW-1:0] div_quotient;
   logic [VW-1:0] div_remainder;

   mkvch_div #(
      .DW(DW),
      .VW(VW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // saturate probabilities and form the sum, the operands for this state, the effective step and the elapsed time
   always_comb begin
      pgb      = (prob_gb_ff > PROB_ONE) ? PROB_ONE : prob_gb_ff;
      pbg      = (prob_bg_ff > PROB_ONE) ? PROB_ONE : prob_bg_ff;
      s_sum    = {1'b0, pgb} + {1'b0, pbg};
      p_same   = bad_ff ? pbg : pgb;
      p_other  = bad_ff ? pgb : pbg;
      step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;
      elapsed  = TW'(req_now_ticks) - last_ff;
   end

   // shared multiplier: operands picked by the sequencer
   always_comb begin
      mul_a = acc_ff;
      mul_b = base_ff;
      unique case (state_ff)
         S_POW_B: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         S_NUM_M: begin
            mul_a = acc_ff;
            mul_b = $signed({1'b0, p_same});
         end
         default: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // drop the fraction bits of the registered product, rounding toward zero
   always_comb begin
      prod_mag = prod_ff[PRW-1] ? PRW'(-prod_ff) : PRW'(prod_ff);
      prod_sh  = prod_mag >> F;
      prod_q   = prod_ff[PRW-1] ? PRW'(-prod_sh) : prod_sh;
      trunc_q  = $signed(prod_q[MW-1:0]);
   end

   // numerator p_other * ONE + pow * p_same and its magnitude
   always_comb begin
      num     = $signed(PRW'(p_other) << F) + prod_ff;
      num_mag = num[PRW-1] ? PRW'(-num) : PRW'(num);
   end

   // flip when draw * ONE exceeds stay * 2^16; with a negative numerator, flip when draw or stay is nonzero
   always_comb begin
      cmp_lhs = CW'(draw_ff) << F;
      cmp_rhs = CW'(div_quotient) << DRAW_W;
      if (neg_ff) begin
         flip = (draw_ff != '0) || (div_quotient != '0);
      end else begin
         flip = (cmp_lhs > cmp_rhs);
      end
   end

   // divider start and operand selection
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DW'(elapsed);
      div_divisor  = VW'(step_eff);
      if (accept) begin
         div_start = 1'b1;
      end else if (state_ff == S_NUM_W) begin
         div_start    = 1'b1;
         div_dividend = DW'(num_mag);
         div_divisor  = VW'(s_sum);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bad_in       = bad_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      adv_in       = adv_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_rate_in  = rsp_rate_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_TDIV;
            end
         end
         S_TDIV: begin
            // step count and the time of the last whole step
            if (div_stat.done) begin
               n_in     = div_quotient[TW-1:0];
               adv_in   = now_ff - TW'(div_remainder);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (n_ff == '0) begin
               state_in = S_DONE;
            end else begin
               last_in = adv_ff;
               acc_in  = Q_ONE;
               base_in = Q_ONE - $signed(s_sum);
               if (s_sum == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_POW_A;
               end
            end
         end
         S_POW_A: begin
            // multiply the accumulator in where the exponent bit is set
            if (n_ff[0]) begin
               prod_in  = mul_p;
               state_in = S_POW_AW;
            end else begin
               state_in = S_POW_B;
            end
         end
         S_POW_AW: begin
            acc_in   = trunc_q;
            state_in = S_POW_B;
         end
         S_POW_B: begin
            // advance the exponent and square the base while bits remain
            n_in = n_ff >> 1;
            if ((n_ff >> 1) != '0) begin
               prod_in  = mul_p;
               state_in = S_POW_BW;
            end else begin
               state_in = S_NUM_M;
            end
         end
         S_POW_BW: begin
            base_in  = trunc_q;
            state_in = S_POW_A;
         end
         S_NUM_M: begin
            prod_in  = mul_p;
            state_in = S_NUM_W;
         end
         S_NUM_W: begin
            neg_in   = num[PRW-1];
            state_in = S_PDIV;
         end
         S_PDIV: begin
            if (div_stat.done) begin
               if (flip) begin
                  bad_in = ~bad_ff;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = bad_ff;
               rsp_rate_in  = bad_ff ? ber_bad_ff : ber_good_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // initial state load from the configuration port
      if (csr_wr_en && (csr_index == CSR_START_BAD)) begin
         bad_in = csr_wdata[0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bad_ff       <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bad_ff       <= bad_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff  <= TW'(req_now_ticks);
         draw_ff <= req_rand_draw;
      end
      n_ff        <= n_in;
      adv_ff      <= adv_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ber_good_ff <= '0;
         ber_bad_ff  <= '0;
         prob_gb_ff  <= '0;
         prob_bg_ff  <= '0;
         step_ff     <= STEP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BER_GOOD: ber_good_ff <= csr_wdata[BER_W-1:0];
            CSR_BER_BAD:  ber_bad_ff  <= csr_wdata[BER_W-1:0];
            CSR_PROB_GB:  prob_gb_ff  <= csr_wdata[PW-1:0];
            CSR_PROB_BG:  prob_bg_ff  <= csr_wdata[PW-1:0];
            CSR_STEP:     step_ff     <= csr_wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_bad = rsp_bad_ff;
   assign rsp_error_rate  = rsp_rate_ff;

endmodule
